### rtl/drr_pkg.sv
// ----------------------------------------------------------------------------
// drr_pkg
// Types and constants shared by the datagram direction router.
// ----------------------------------------------------------------------------
`default_nettype none

package drr_pkg;

    // header checks
    localparam logic [31:0] MAGIC_VALUE = 32'hADBC_CBDA;
    localparam logic [15:0] MIN_LENGTH  = 16'd12;

    // routing decision
    typedef enum logic [1:0] {
        ACT_FANOUT  = 2'd0,
        ACT_SOURCE  = 2'd1,
        ACT_DROP    = 2'd2,
        ACT_CLEARED = 2'd3
    } drr_action_t;

    // packet class
    typedef enum logic [1:0] {
        CLS_UNKNOWN = 2'd0,
        CLS_APPS    = 2'd1,
        CLS_SOURCE  = 2'd2,
        CLS_AMBIG   = 2'd3
    } drr_class_t;

    // request kind
    typedef enum logic {
        REQ_ROUTE = 1'b0,
        REQ_CLEAR = 1'b1
    } drr_req_t;

    // input item
    typedef struct packed {
        logic        req_type;
        logic [15:0] pkt_length;
        logic [31:0] magic_word;
        logic [31:0] msg_type;
        logic [31:0] src_ip;
        logic [15:0] src_port;
    } drr_in_t;

    // result item
    typedef struct packed {
        drr_action_t action;
        drr_class_t  pkt_class;
        logic [31:0] dest_ip;
        logic [15:0] dest_port;
        logic [31:0] fanout_packets;
        logic [47:0] fanout_bytes;
        logic [31:0] reverse_packets;
        logic [47:0] reverse_bytes;
        logic [31:0] dropped_packets;
        logic [31:0] unknown_packets;
    } drr_out_t;

    // header classification by length, magic word and message type
    function automatic drr_class_t drr_classify(
        input logic [15:0] len,
        input logic [31:0] magic,
        input logic [31:0] mtype
    );
        drr_class_t cls;
        cls = CLS_UNKNOWN;
        if (len >= MIN_LENGTH && magic == MAGIC_VALUE && mtype[31:4] == 28'd0) begin
            unique case (mtype[3:0])
                4'd1, 4'd2, 4'd5, 4'd10, 4'd12: cls = CLS_APPS;
                4'd0, 4'd3, 4'd6:                cls = CLS_AMBIG;
                default:                         cls = CLS_SOURCE;
            endcase
        end
        return cls;
    endfunction

endpackage

`default_nettype wire

### rtl/datagram_direction_router.sv
// ----------------------------------------------------------------------------
// datagram_direction_router
// Classifies datagram headers and picks fan-out, send-to-source or drop.
// ----------------------------------------------------------------------------
// Accepts one header (or one counter-clear request) per clock and returns one
// result per item: the item is captured in an input register, classified and
// routed against the learned endpoint and the traffic counters in one pass, and
// the decision with the updated counters is held in an output register.
// Throughput is one item per cycle whenever the result side takes transfers; a
// stalled result holds the input register and then s_ready. allow_reverse
// resets to 1 and is written through cfg_wr_en.
// Counters wrap at their widths; a clear item zeroes them and keeps the
// learned endpoint.
// ----------------------------------------------------------------------------
`default_nettype none

module datagram_direction_router (
    input  wire                 aclk,
    input  wire                 aresetn,
    input  wire                 cfg_wr_en,
    input  wire                 cfg_wr_data,
    input  wire                 s_valid,
    output logic                s_ready,
    input  wire drr_pkg::drr_in_t s_data,
    output logic                m_valid,
    input  wire                 m_ready,
    output drr_pkg::drr_out_t   m_data
);

    import drr_pkg::*;

    // registers
    logic        allow_reverse_reg;
    logic        in_valid_reg;
    drr_in_t     in_data_reg;
    logic        out_valid_reg;
    drr_out_t    out_data_reg;
    logic        have_source_reg, have_source_next;
    logic [31:0] learned_ip_reg, learned_ip_next;
    logic [15:0] learned_port_reg, learned_port_next;
    logic [31:0] fanout_pkt_reg, fanout_pkt_next;
    logic [47:0] fanout_byte_reg, fanout_byte_next;
    logic [31:0] reverse_pkt_reg, reverse_pkt_next;
    logic [47:0] reverse_byte_reg, reverse_byte_next;
    logic [31:0] drop_reg, drop_next;
    logic [31:0] unknown_reg, unknown_next;
    drr_out_t    out_data_next;

    // decision terms
    logic        out_free;
    logic        work_fire;
    drr_class_t  cls;
    drr_action_t act;
    logic        same_src;
    logic        do_fanout;
    logic        do_source;
    logic        inc_drop;
    logic        inc_unknown;

    // handshake between input register and output register
    assign out_free  = !out_valid_reg || m_ready;
    assign work_fire = in_valid_reg && out_free;
    assign s_ready   = !in_valid_reg || work_fire;
    assign m_valid   = out_valid_reg;
    assign m_data    = out_data_reg;

    // classification and routing choice
    always_comb begin
        cls         = CLS_UNKNOWN;
        act         = ACT_DROP;
        do_fanout   = 1'b0;
        do_source   = 1'b0;
        inc_drop    = 1'b0;
        inc_unknown = 1'b0;
        same_src    = have_source_reg && learned_ip_reg == in_data_reg.src_ip
                      && learned_port_reg == in_data_reg.src_port;
        if (in_data_reg.req_type == REQ_CLEAR) begin
            act = ACT_CLEARED;
        end else begin
            cls = drr_classify(in_data_reg.pkt_length, in_data_reg.magic_word,
                               in_data_reg.msg_type);
            priority if (cls == CLS_SOURCE && !allow_reverse_reg) begin
                inc_drop = 1'b1;
            end else if (cls == CLS_APPS) begin
                do_fanout = 1'b1;
            end else if (cls == CLS_SOURCE) begin
                do_source = 1'b1;
            end else if (cls == CLS_AMBIG) begin
                if (!same_src && allow_reverse_reg && have_source_reg) begin
                    do_source = 1'b1;
                end else begin
                    do_fanout = 1'b1;
                end
            end else begin
                if (same_src) begin
                    do_fanout = 1'b1;
                end else if (!have_source_reg) begin
                    inc_unknown = 1'b1;
                    do_fanout   = 1'b1;
                end else begin
                    inc_unknown = 1'b1;
                    inc_drop    = 1'b1;
                end
            end
            // send to source with no learned endpoint becomes a drop
            if (do_source && !have_source_reg) begin
                inc_drop = 1'b1;
            end
            if (do_fanout) begin
                act = ACT_FANOUT;
            end else if (do_source && have_source_reg) begin
                act = ACT_SOURCE;
            end else begin
                act = ACT_DROP;
            end
        end
    end

    // endpoint learning and counter updates
    always_comb begin
        have_source_next  = have_source_reg;
        learned_ip_next   = learned_ip_reg;
        learned_port_next = learned_port_reg;
        fanout_pkt_next   = fanout_pkt_reg;
        fanout_byte_next  = fanout_byte_reg;
        reverse_pkt_next  = reverse_pkt_reg;
        reverse_byte_next = reverse_byte_reg;
        drop_next         = drop_reg;
        unknown_next      = unknown_reg;
        if (in_data_reg.req_type == REQ_CLEAR) begin
            fanout_pkt_next   = '0;
            fanout_byte_next  = '0;
            reverse_pkt_next  = '0;
            reverse_byte_next = '0;
            drop_next         = '0;
            unknown_next      = '0;
        end else begin
            if (do_fanout) begin
                have_source_next  = 1'b1;
                learned_ip_next   = in_data_reg.src_ip;
                learned_port_next = in_data_reg.src_port;
                fanout_pkt_next   = fanout_pkt_reg + 32'd1;
                fanout_byte_next  = fanout_byte_reg + {32'd0, in_data_reg.pkt_length};
            end
            if (do_source) begin
                reverse_pkt_next  = reverse_pkt_reg + 32'd1;
                reverse_byte_next = reverse_byte_reg + {32'd0, in_data_reg.pkt_length};
            end
            if (inc_drop) begin
                drop_next = drop_reg + 32'd1;
            end
            if (inc_unknown) begin
                unknown_next = unknown_reg + 32'd1;
            end
        end
    end

    // result assembly
    always_comb begin
        out_data_next.action          = act;
        out_data_next.pkt_class       = cls;
        out_data_next.dest_ip         = (act == ACT_SOURCE) ? learned_ip_reg : 32'd0;
        out_data_next.dest_port       = (act == ACT_SOURCE) ? learned_port_reg : 16'd0;
        out_data_next.fanout_packets  = fanout_pkt_next;
        out_data_next.fanout_bytes    = fanout_byte_next;
        out_data_next.reverse_packets = reverse_pkt_next;
        out_data_next.reverse_bytes   = reverse_byte_next;
        out_data_next.dropped_packets = drop_next;
        out_data_next.unknown_packets = unknown_next;
    end

    // control and state registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            allow_reverse_reg <= 1'b1;
            in_valid_reg      <= 1'b0;
            out_valid_reg     <= 1'b0;
            have_source_reg   <= 1'b0;
            learned_ip_reg    <= '0;
            learned_port_reg  <= '0;
            fanout_pkt_reg    <= '0;
            fanout_byte_reg   <= '0;
            reverse_pkt_reg   <= '0;
            reverse_byte_reg  <= '0;
            drop_reg          <= '0;
            unknown_reg       <= '0;
        end else begin
            if (cfg_wr_en) begin
                allow_reverse_reg <= cfg_wr_data;
            end
            if (s_ready) begin
                in_valid_reg <= s_valid;
            end
            if (out_free) begin
                out_valid_reg <= in_valid_reg;
            end
            if (work_fire) begin
                have_source_reg  <= have_source_next;
                learned_ip_reg   <= learned_ip_next;
                learned_port_reg <= learned_port_next;
                fanout_pkt_reg   <= fanout_pkt_next;
                fanout_byte_reg  <= fanout_byte_next;
                reverse_pkt_reg  <= reverse_pkt_next;
                reverse_byte_reg <= reverse_byte_next;
                drop_reg         <= drop_next;
                unknown_reg      <= unknown_next;
            end
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_data_reg <= s_data;
        end
        if (work_fire) begin
            out_data_reg <= out_data_next;
        end
    end

    // a send to source only goes out with a learned endpoint
    assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg && out_data_reg.action == ACT_SOURCE |-> have_source_reg)
        else $error("send to source without learned endpoint");

    // destination is zero unless the result goes to the source
    assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg && out_data_reg.action != ACT_SOURCE
        |-> out_data_reg.dest_ip == 32'd0 && out_data_reg.dest_port == 16'd0)
        else $error("destination set on non-source result");

    // a clear result carries zeroed counters
    assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg && out_data_reg.action == ACT_CLEARED
        |-> out_data_reg.fanout_packets == 32'd0 && out_data_reg.fanout_bytes == 48'd0
            && out_data_reg.reverse_packets == 32'd0
            && out_data_reg.reverse_bytes == 48'd0
            && out_data_reg.dropped_packets == 32'd0
            && out_data_reg.unknown_packets == 32'd0)
        else $error("clear result with nonzero counters");

    // a fan-out transfer leaves an endpoint learned
    assert property (@(posedge aclk) disable iff (!aresetn)
        work_fire && act == ACT_FANOUT |=> have_source_reg)
        else $error("fan-out did not learn the sender");

    // the input register only blocks while it holds an item
    assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> in_valid_reg && !out_free)
        else $error("input stalled without a pending item");

endmodule

`default_nettype wire

### dv/datagram_direction_router_test.sv
// ----------------------------------------------------------------------------
// datagram_direction_router_test
// Self-checking bench for the datagram direction router.
// ----------------------------------------------------------------------------
// Headers are queued by the stimulus process and sent in random bursts. Each
// transfer into the block is routed by a predictor that keeps its own learned
// endpoint, traffic counters and allow_reverse copy. Every result transfer is
// compared field by field with the oldest prediction. The run covers directed
// corner headers with reverse relay on and off, then random traffic from a
// small endpoint pool, with a long result-side stall that backs up the input.
// ----------------------------------------------------------------------------
`default_nettype none

module datagram_direction_router_test;

    import drr_pkg::*;

    logic     aclk        = 1'b0;
    logic     aresetn     = 1'b0;
    logic     cfg_wr_en   = 1'b0;
    logic     cfg_wr_data = 1'b0;
    logic     s_valid     = 1'b0;
    logic     s_ready;
    drr_in_t  s_data      = '0;
    logic     m_valid;
    logic     m_ready     = 1'b0;
    drr_out_t m_data;

    datagram_direction_router u_dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_data      (s_data),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_data      (m_data)
    );

    // headers waiting to be sent, and routing results still to arrive
    drr_in_t  pending_headers[$];
    drr_out_t predicted_results[$];
    int       error_count   = 0;
    int       queued_total  = 0;
    int       checked_total = 0;

    // predictor state
    logic        reverse_enabled = 1'b1;
    logic        src_known       = 1'b0;
    logic [31:0] known_ip        = '0;
    logic [15:0] known_port      = '0;
    logic [31:0] fanout_pkts     = '0;
    logic [47:0] fanout_octets   = '0;
    logic [31:0] reverse_pkts    = '0;
    logic [47:0] reverse_octets  = '0;
    logic [31:0] drop_pkts       = '0;
    logic [31:0] unknown_pkts    = '0;

    // sender endpoints for random traffic
    logic [31:0] ip_pool [4];
    logic [15:0] port_pool [4];

    // sender burst and receiver stall pattern
    int   burst_left   = 0;
    int   gap_left     = 0;
    int   stretch_left = 0;
    int   ready_mode   = 0;
    int   holdoff_left = 0;
    logic holdoff_done = 1'b0;
    logic want_holdoff = 1'b0;

    initial begin
        forever #5 aclk = ~aclk;
    end

    initial begin
        #5_000_000;
        $display("datagram_direction_router_test: done, errors");
        $finish;
    end

    // fan-out learns the sender and counts the packet toward applications
    function automatic drr_action_t take_fanout(input drr_in_t h);
        known_ip      = h.src_ip;
        known_port    = h.src_port;
        src_known     = 1'b1;
        fanout_pkts   = fanout_pkts + 32'd1;
        fanout_octets = fanout_octets + 48'(h.pkt_length);
        return ACT_FANOUT;
    endfunction

    // reverse path counts the packet, dropped if nobody is learned yet
    function automatic drr_action_t take_reverse(input drr_in_t h);
        reverse_pkts   = reverse_pkts + 32'd1;
        reverse_octets = reverse_octets + 48'(h.pkt_length);
        if (!src_known) begin
            drop_pkts = drop_pkts + 32'd1;
            return ACT_DROP;
        end
        return ACT_SOURCE;
    endfunction

    // routing decision and counter snapshot for one header
    function automatic drr_out_t route_header(input drr_in_t h);
        drr_out_t    r;
        drr_class_t  cls;
        drr_action_t act;
        logic        same;
        cls = CLS_UNKNOWN;
        if (h.req_type == REQ_CLEAR) begin
            fanout_pkts    = '0;
            fanout_octets  = '0;
            reverse_pkts   = '0;
            reverse_octets = '0;
            drop_pkts      = '0;
            unknown_pkts   = '0;
            act            = ACT_CLEARED;
        end else begin
            if (h.pkt_length >= MIN_LENGTH && h.magic_word == MAGIC_VALUE) begin
                case (h.msg_type)
                    32'd1, 32'd2, 32'd5, 32'd10, 32'd12: cls = CLS_APPS;
                    32'd4, 32'd7, 32'd8, 32'd9, 32'd11,
                    32'd13, 32'd14, 32'd15:              cls = CLS_SOURCE;
                    32'd0, 32'd3, 32'd6:                 cls = CLS_AMBIG;
                    default:                             cls = CLS_UNKNOWN;
                endcase
            end
            same = src_known && h.src_ip == known_ip && h.src_port == known_port;
            if (cls == CLS_SOURCE && !reverse_enabled) begin
                drop_pkts = drop_pkts + 32'd1;
                act       = ACT_DROP;
            end else if (cls == CLS_APPS) begin
                act = take_fanout(h);
            end else if (cls == CLS_SOURCE) begin
                act = take_reverse(h);
            end else if (cls == CLS_AMBIG) begin
                if (!same && reverse_enabled && src_known)
                    act = take_reverse(h);
                else
                    act = take_fanout(h);
            end else if (same) begin
                act = take_fanout(h);
            end else if (!src_known) begin
                unknown_pkts = unknown_pkts + 32'd1;
                act          = take_fanout(h);
            end else begin
                unknown_pkts = unknown_pkts + 32'd1;
                drop_pkts    = drop_pkts + 32'd1;
                act          = ACT_DROP;
            end
        end
        r.action          = act;
        r.pkt_class       = cls;
        r.dest_ip         = (act == ACT_SOURCE) ? known_ip : '0;
        r.dest_port       = (act == ACT_SOURCE) ? known_port : '0;
        r.fanout_packets  = fanout_pkts;
        r.fanout_bytes    = fanout_octets;
        r.reverse_packets = reverse_pkts;
        r.reverse_bytes   = reverse_octets;
        r.dropped_packets = drop_pkts;
        r.unknown_packets = unknown_pkts;
        return r;
    endfunction

    function automatic drr_in_t make_header(
        input drr_req_t    req,
        input logic [15:0] len,
        input logic [31:0] magic,
        input logic [31:0] mtype,
        input logic [31:0] ip,
        input logic [15:0] port
    );
        drr_in_t h;
        h.req_type   = req;
        h.pkt_length = len;
        h.magic_word = magic;
        h.msg_type   = mtype;
        h.src_ip     = ip;
        h.src_port   = port;
        return h;
    endfunction

    // add one header to the send queue and count it as owed a result
    function automatic void enqueue_header(input drr_in_t h);
        pending_headers = {pending_headers, h};
        queued_total++;
    endfunction

    // mostly well-formed headers from a small endpoint pool, plus noise
    function automatic drr_in_t random_header();
        drr_in_t h;
        int      pick;
        int      slot;
        pick = $urandom_range(0, 99);
        slot = $urandom_range(0, 3);
        if ($urandom_range(0, 39) == 0) begin
            ip_pool[slot]   = $urandom();
            port_pool[slot] = 16'($urandom());
        end
        h = make_header(REQ_ROUTE, 16'($urandom_range(12, 65535)), MAGIC_VALUE,
                        $urandom_range(0, 15), ip_pool[slot], port_pool[slot]);
        if (pick < 3)
            h = make_header(REQ_CLEAR, 16'($urandom()), $urandom(), $urandom(),
                            $urandom(), 16'($urandom()));
        else if (pick < 8)
            h.msg_type = $urandom();
        else if (pick < 12)
            h.msg_type = $urandom_range(16, 40);
        else if (pick < 16)
            h.pkt_length = 16'($urandom_range(0, 11));
        else if (pick < 20)
            h.magic_word = $urandom();
        else if (pick < 23)
            h.magic_word = MAGIC_VALUE ^ (32'd1 << $urandom_range(0, 31));
        else if (pick < 30)
            h.src_port = 16'($urandom());
        return h;
    endfunction

    task automatic queue_random(input int count);
        repeat (count) enqueue_header(random_header());
    endtask

    // wait until every queued header has come back as a checked result
    task automatic drain_phase();
        while (checked_total != queued_total)
            @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic write_allow_reverse(input logic value);
        @(posedge aclk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(posedge aclk);
        cfg_wr_en       <= 1'b0;
        reverse_enabled  = value;
    endtask

    task automatic check_field(input string name, input logic [63:0] want,
                               input logic [63:0] got);
        if (got !== want) begin
            $error("%s: expected %0h, got %0h", name, want, got);
            error_count++;
        end
    endtask

    // header driver: random bursts, prediction on each input transfer
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready)
                predicted_results = {predicted_results, route_header(s_data)};
            if (!s_valid || s_ready) begin
                if (gap_left > 0) begin
                    gap_left <= gap_left - 1;
                    s_valid  <= 1'b0;
                end else if (pending_headers.size() != 0) begin
                    s_data  <= pending_headers.pop_front();
                    s_valid <= 1'b1;
                    if (burst_left <= 1) begin
                        burst_left <= $urandom_range(1, 48);
                        gap_left   <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 10);
                    end else begin
                        burst_left <= burst_left - 1;
                    end
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // result-side ready: changing stall patterns and one long hold-off
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else if (holdoff_left > 0) begin
            holdoff_left <= holdoff_left - 1;
            m_ready      <= 1'b0;
        end else if (want_holdoff && !holdoff_done) begin
            holdoff_done <= 1'b1;
            holdoff_left <= 400;
            m_ready      <= 1'b0;
        end else begin
            if (stretch_left == 0) begin
                ready_mode   <= $urandom_range(0, 3);
                stretch_left <= $urandom_range(5, 80);
            end else begin
                stretch_left <= stretch_left - 1;
            end
            case (ready_mode)
                0: m_ready <= 1'b1;
                1: m_ready <= 1'($urandom_range(0, 1));
                2: m_ready <= ($urandom_range(0, 3) == 0);
                default: m_ready <= ~m_ready;
            endcase
        end
    end

    // result monitor: compare each result transfer with the oldest prediction
    always @(posedge aclk) begin : result_monitor
        drr_out_t want;
        if (aresetn && m_valid && m_ready) begin
            checked_total++;
            if (predicted_results.size() == 0) begin
                $error("result transfer with no prediction waiting: %0h", m_data);
                error_count++;
            end else begin
                want = predicted_results.pop_front();
                check_field("action", 64'(want.action), 64'(m_data.action));
                check_field("pkt_class", 64'(want.pkt_class), 64'(m_data.pkt_class));
                check_field("dest_ip", 64'(want.dest_ip), 64'(m_data.dest_ip));
                check_field("dest_port", 64'(want.dest_port), 64'(m_data.dest_port));
                check_field("fanout_packets", 64'(want.fanout_packets),
                            64'(m_data.fanout_packets));
                check_field("fanout_bytes", 64'(want.fanout_bytes),
                            64'(m_data.fanout_bytes));
                check_field("reverse_packets", 64'(want.reverse_packets),
                            64'(m_data.reverse_packets));
                check_field("reverse_bytes", 64'(want.reverse_bytes),
                            64'(m_data.reverse_bytes));
                check_field("dropped_packets", 64'(want.dropped_packets),
                            64'(m_data.dropped_packets));
                check_field("unknown_packets", 64'(want.unknown_packets),
                            64'(m_data.unknown_packets));
            end
        end
    end

    // stimulus phases
    initial begin
        for (int i = 0; i < 4; i++) begin
            ip_pool[i]   = $urandom();
            port_pool[i] = 16'($urandom());
        end
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        repeat (2) @(posedge aclk);

        // reverse relay at its reset value, nothing learned yet
        enqueue_header(make_header(REQ_ROUTE, 16'd40, MAGIC_VALUE, 32'd4,
                                   32'h0A00_0003, 16'd3000));
        enqueue_header(make_header(REQ_ROUTE, 16'd0, 32'h0000_0000,
                                   32'd1, 32'h0A00_0001, 16'd1000));
        enqueue_header(make_header(REQ_ROUTE, 16'hFFFF, MAGIC_VALUE, 32'd1,
                                   32'h0A00_0002, 16'd2237));
        enqueue_header(make_header(REQ_ROUTE, 16'd100, MAGIC_VALUE, 32'd15,
                                   32'h0A00_0003, 16'd3000));
        enqueue_header(make_header(REQ_ROUTE, 16'd60, MAGIC_VALUE, 32'd3,
                                   32'h0A00_0002, 16'd2237));
        enqueue_header(make_header(REQ_ROUTE, 16'd61, MAGIC_VALUE, 32'd6,
                                   32'h0A00_0003, 16'd3000));
        enqueue_header(make_header(REQ_ROUTE, 16'd62, MAGIC_VALUE, 32'd16,
                                   32'h0A00_0003, 16'd3000));
        enqueue_header(make_header(REQ_ROUTE, 16'd63, MAGIC_VALUE, 32'hFFFF_FFFF,
                                   32'h0A00_0002, 16'd2237));
        enqueue_header(make_header(REQ_ROUTE, 16'd12, 32'hFFFF_FFFF, 32'd2,
                                   32'h0A00_0002, 16'd2237));
        enqueue_header(make_header(REQ_ROUTE, 16'd12, MAGIC_VALUE, 32'd2,
                                   32'h0000_0000, 16'h0000));
        enqueue_header(make_header(REQ_ROUTE, 16'd11, MAGIC_VALUE, 32'd5,
                                   32'h0000_0000, 16'h0000));
        enqueue_header(make_header(REQ_ROUTE, 16'hFFFF, MAGIC_VALUE, 32'd10,
                                   32'hFFFF_FFFF, 16'hFFFF));
        enqueue_header(make_header(REQ_ROUTE, 16'd500, MAGIC_VALUE, 32'd12,
                                   32'hFFFF_FFFF, 16'hFFFF));
        enqueue_header(make_header(REQ_ROUTE, 16'd70, MAGIC_VALUE, 32'd0,
                                   32'hFFFF_FFFF, 16'hFFFE));
        enqueue_header(make_header(REQ_CLEAR, 16'hFFFF, 32'hFFFF_FFFF,
                                   32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF));
        enqueue_header(make_header(REQ_ROUTE, 16'd80, MAGIC_VALUE, 32'd7,
                                   32'h0A00_0003, 16'd3000));
        drain_phase();

        // reverse relay disabled
        write_allow_reverse(1'b0);
        enqueue_header(make_header(REQ_ROUTE, 16'd90, MAGIC_VALUE, 32'd9,
                                   32'h0A00_0003, 16'd3000));
        enqueue_header(make_header(REQ_ROUTE, 16'd91, MAGIC_VALUE, 32'd0,
                                   32'h0A00_0003, 16'd3000));
        enqueue_header(make_header(REQ_ROUTE, 16'd92, MAGIC_VALUE, 32'd3,
                                   32'h0A00_0003, 16'd3000));
        enqueue_header(make_header(REQ_ROUTE, 16'd93, MAGIC_VALUE, 32'd20,
                                   32'h0A00_0002, 16'd2237));
        enqueue_header(make_header(REQ_ROUTE, 16'd94, MAGIC_VALUE, 32'd5,
                                   32'h0A00_0002, 16'd2237));
        enqueue_header(make_header(REQ_CLEAR, 16'd0, 32'd0, 32'd0,
                                   32'd0, 16'd0));
        drain_phase();

        // random traffic, relay on, with a long result-side stall
        write_allow_reverse(1'b1);
        queue_random(900);
        want_holdoff = 1'b1;
        drain_phase();

        write_allow_reverse(1'b0);
        queue_random(500);
        drain_phase();

        write_allow_reverse(1'b1);
        queue_random(450);
        drain_phase();

        repeat (20) @(posedge aclk);
        if (error_count == 0)
            $display("datagram_direction_router_test: done, clean");
        else
            $display("datagram_direction_router_test: done, errors");
        $finish;
    end

endmodule

`default_nettype wire
